### sv/prf_pkg.sv
package prf_pkg;

    localparam int CORE_SLOTS   = 64;
    localparam int FILTER_SLOTS = 64;

    localparam int CORE_AW = (CORE_SLOTS > 1) ? $clog2(CORE_SLOTS) : 1;
    localparam int FILT_AW = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
    localparam int CIDX_W  = $clog2(CORE_SLOTS + 1);
    localparam int FIDX_W  = $clog2(FILTER_SLOTS + 1);
    localparam int IDX_W   = (CIDX_W > FIDX_W) ? CIDX_W : FIDX_W;

    localparam int DATA_W  = 64;
    localparam int BASE_W  = 32;
    localparam int CNT_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int KIND_W  = 2;
    localparam int POW_W   = 5;
    localparam int MASK_W  = 64;
    localparam int SYM_W   = 2;
    localparam int FENT_W  = KIND_W + 2 * SLOT_W;
    localparam int PADDR_W = 4;

    localparam logic [BASE_W-1:0] BASE_RESET = 32'd2;

    typedef enum logic [1:0] {
        OP_LOAD_CORE   = 2'd0,
        OP_LOAD_FILTER = 2'd1,
        OP_TEST        = 2'd2,
        OP_NONE        = 2'd3
    } t_op;

    localparam logic [SYM_W-1:0] SYM_ZERO  = 2'd0;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_MINUS = 2'd2;

    localparam logic [1:0] REG_BASE      = 2'd0;
    localparam logic [1:0] REG_CORE_CNT  = 2'd1;
    localparam logic [1:0] REG_FILT_CNT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORE_RD,
        S_CORE_LD,
        S_CORE_JAC,
        S_BASE_LD,
        S_BASE_JAC,
        S_FILT_RD,
        S_FILT_SYM,
        S_FILT_EVAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start_test;
        logic             core_wr;
        logic             filt_wr;
        logic             core_ld;
        logic             base_ld;
        logic             jac_step;
        logic             sym_wr;
        logic             base_wr;
        logic             filt_sym;
        logic             filt_eval;
        logic             publish;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] ncore;
    } t_cmd;

    typedef struct packed {
        logic jac_done;
    } t_stat;

endpackage

### sv/prf_ram.sv
module prf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/prf_dp.sv
module prf_dp (
    input  logic                                i_clk,
    input  prf_pkg::t_cmd                       i_cmd,
    input  logic [prf_pkg::SLOT_W-1:0]          i_slot,
    input  logic [prf_pkg::DATA_W-1:0]          i_core_value,
    input  logic [prf_pkg::KIND_W-1:0]          i_filter_kind,
    input  logic [prf_pkg::SLOT_W-1:0]          i_k_slot,
    input  logic [prf_pkg::SLOT_W-1:0]          i_c_slot,
    input  logic [prf_pkg::DATA_W-1:0]          i_prime,
    input  logic [prf_pkg::BASE_W-1:0]          i_base,
    output prf_pkg::t_stat                      o_stat,
    output logic [prf_pkg::POW_W-1:0]           o_power_two_mask,
    output logic [prf_pkg::MASK_W-1:0]          o_residue_pass_mask
);

    logic [prf_pkg::DATA_W-1:0] w_core_rdata;
    logic [prf_pkg::FENT_W-1:0] w_filt_rdata;
    logic [prf_pkg::SYM_W-1:0]  w_sym_k;
    logic [prf_pkg::SYM_W-1:0]  w_sym_c;
    logic [prf_pkg::SYM_W-1:0]  w_code;
    logic [prf_pkg::POW_W-1:0]  w_pow;
    logic                       w_core_we;
    logic                       w_filt_we;
    logic [prf_pkg::SLOT_W-1:0] w_ks;
    logic [prf_pkg::SLOT_W-1:0] w_cs;
    logic [prf_pkg::SYM_W-1:0]  w_sk;
    logic [prf_pkg::SYM_W-1:0]  w_sc;
    logic                       w_pass;

    logic [prf_pkg::DATA_W-1:0] r_a;
    logic [prf_pkg::DATA_W-1:0] r_n;
    logic                       r_neg;
    logic [prf_pkg::DATA_W-1:0] r_p;
    logic [prf_pkg::POW_W-1:0]  r_pow;
    logic [prf_pkg::MASK_W-1:0] r_pass;
    logic                       r_nonres;
    logic [prf_pkg::KIND_W-1:0] r_kind;
    logic                       r_k_ok;
    logic                       r_c_ok;

    assign w_core_we = i_cmd.core_wr && (int'(i_slot) < prf_pkg::CORE_SLOTS);
    assign w_filt_we = i_cmd.filt_wr && (int'(i_slot) < prf_pkg::FILTER_SLOTS);

    prf_ram #(.WIDTH(prf_pkg::DATA_W), .DEPTH(prf_pkg::CORE_SLOTS)) u_core_ram (
        .i_clk   (i_clk),
        .i_we    (w_core_we),
        .i_waddr (prf_pkg::CORE_AW'(i_slot)),
        .i_wdata (i_core_value),
        .i_raddr (i_cmd.idx[prf_pkg::CORE_AW-1:0]),
        .o_rdata (w_core_rdata)
    );

    prf_ram #(.WIDTH(prf_pkg::FENT_W), .DEPTH(prf_pkg::FILTER_SLOTS)) u_filt_ram (
        .i_clk   (i_clk),
        .i_we    (w_filt_we),
        .i_waddr (prf_pkg::FILT_AW'(i_slot)),
        .i_wdata ({i_filter_kind, i_k_slot, i_c_slot}),
        .i_raddr (i_cmd.idx[prf_pkg::FILT_AW-1:0]),
        .o_rdata (w_filt_rdata)
    );

    assign w_ks = w_filt_rdata[2*prf_pkg::SLOT_W-1:prf_pkg::SLOT_W];
    assign w_cs = w_filt_rdata[prf_pkg::SLOT_W-1:0];

    // two copies of the symbol table so k and c are looked up together
    prf_ram #(.WIDTH(prf_pkg::SYM_W), .DEPTH(prf_pkg::CORE_SLOTS)) u_sym_k_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sym_wr),
        .i_waddr (i_cmd.idx[prf_pkg::CORE_AW-1:0]),
        .i_wdata (w_code),
        .i_raddr (prf_pkg::CORE_AW'(w_ks)),
        .o_rdata (w_sym_k)
    );

    prf_ram #(.WIDTH(prf_pkg::SYM_W), .DEPTH(prf_pkg::CORE_SLOTS)) u_sym_c_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sym_wr),
        .i_waddr (i_cmd.idx[prf_pkg::CORE_AW-1:0]),
        .i_wdata (w_code),
        .i_raddr (prf_pkg::CORE_AW'(w_cs)),
        .o_rdata (w_sym_c)
    );

    assign o_stat.jac_done = (r_a == '0) || !r_n[0];

    always_comb begin
        if (!r_n[0] || (r_n != prf_pkg::DATA_W'(1))) begin
            w_code = prf_pkg::SYM_ZERO;
        end else if (r_neg) begin
            w_code = prf_pkg::SYM_MINUS;
        end else begin
            w_code = prf_pkg::SYM_PLUS;
        end
    end

    assign w_pow = {i_prime[5:0] == 6'd1, i_prime[4:0] == 5'd1, i_prime[3:0] == 4'd1,
                    i_prime[2:0] == 3'd1, i_prime[1:0] == 2'd1};

    assign w_sk   = r_k_ok ? w_sym_k : prf_pkg::SYM_ZERO;
    assign w_sc   = r_c_ok ? w_sym_c : prf_pkg::SYM_ZERO;
    assign w_pass = (w_sk == w_sc) ^ ((r_p[1] && r_kind[1]) ^ (r_nonres && r_kind[0]));

    // binary Jacobi: one halving, swap or subtract per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.core_ld) begin
            r_a   <= w_core_rdata;
            r_n   <= r_p;
            r_neg <= 1'b0;
        end else if (i_cmd.base_ld) begin
            r_a   <= prf_pkg::DATA_W'(i_base);
            r_n   <= r_p;
            r_neg <= 1'b0;
        end else if (i_cmd.jac_step) begin
            if (!r_a[0]) begin
                r_a <= r_a >> 1;
                if ((r_n[2:0] == 3'd3) || (r_n[2:0] == 3'd5)) begin
                    r_neg <= !r_neg;
                end
            end else if (r_a < r_n) begin
                r_a <= r_n;
                r_n <= r_a;
                if ((r_a[1:0] == 2'd3) && (r_n[1:0] == 2'd3)) begin
                    r_neg <= !r_neg;
                end
            end else begin
                r_a <= r_a - r_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_test) begin
            r_p    <= i_prime;
            r_pow  <= w_pow;
            r_pass <= '0;
        end
        if (i_cmd.base_wr) begin
            r_nonres <= (w_code != prf_pkg::SYM_PLUS);
        end
        if (i_cmd.filt_sym) begin
            r_kind <= w_filt_rdata[prf_pkg::FENT_W-1:2*prf_pkg::SLOT_W];
            r_k_ok <= int'(w_ks) < int'(i_cmd.ncore);
            r_c_ok <= int'(w_cs) < int'(i_cmd.ncore);
        end
        if (i_cmd.filt_eval) begin
            r_pass[i_cmd.idx[prf_pkg::FILT_AW-1:0]] <= w_pass;
        end
        if (i_cmd.publish) begin
            o_power_two_mask    <= r_pow;
            o_residue_pass_mask <= r_pass;
        end
    end

endmodule

### sv/prf_ctrl.sv
module prf_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [1:0]                 i_operation,
    input  logic [prf_pkg::CNT_W-1:0]  i_core_count,
    input  logic [prf_pkg::CNT_W-1:0]  i_filter_count,
    input  logic                       i_stall,
    input  prf_pkg::t_stat             i_stat,
    output prf_pkg::t_cmd              o_cmd,
    output logic                       o_stall,
    output logic                       o_valid
);

    prf_pkg::t_state            r_state, n_state;
    logic [prf_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                       r_valid, n_valid;
    logic [prf_pkg::IDX_W-1:0]  w_ncore;
    logic [prf_pkg::IDX_W-1:0]  w_nfilt;
    logic [prf_pkg::IDX_W-1:0]  w_idx_inc;

    assign w_ncore = (int'(i_core_count) > prf_pkg::CORE_SLOTS) ?
                     prf_pkg::IDX_W'(prf_pkg::CORE_SLOTS) : prf_pkg::IDX_W'(i_core_count);
    assign w_nfilt = (int'(i_filter_count) > prf_pkg::FILTER_SLOTS) ?
                     prf_pkg::IDX_W'(prf_pkg::FILTER_SLOTS) : prf_pkg::IDX_W'(i_filter_count);
    assign w_idx_inc = r_idx + 1'b1;

    assign o_stall = (r_state != prf_pkg::S_IDLE);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prf_pkg::S_IDLE;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_valid = r_valid && i_stall;
        o_cmd   = '0;
        o_cmd.idx   = r_idx;
        o_cmd.ncore = w_ncore;
        unique case (r_state)
            prf_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (prf_pkg::t_op'(i_operation))
                        prf_pkg::OP_LOAD_CORE:   o_cmd.core_wr = 1'b1;
                        prf_pkg::OP_LOAD_FILTER: o_cmd.filt_wr = 1'b1;
                        prf_pkg::OP_TEST: begin
                            o_cmd.start_test = 1'b1;
                            n_idx = '0;
                            n_state = (w_ncore == '0) ? prf_pkg::S_BASE_LD
                                                      : prf_pkg::S_CORE_RD;
                        end
                        default: ;
                    endcase
                end
            end
            prf_pkg::S_CORE_RD: n_state = prf_pkg::S_CORE_LD;
            prf_pkg::S_CORE_LD: begin
                o_cmd.core_ld = 1'b1;
                n_state = prf_pkg::S_CORE_JAC;
            end
            prf_pkg::S_CORE_JAC: begin
                if (i_stat.jac_done) begin
                    o_cmd.sym_wr = 1'b1;
                    n_idx = w_idx_inc;
                    n_state = (w_idx_inc == w_ncore) ? prf_pkg::S_BASE_LD
                                                     : prf_pkg::S_CORE_RD;
                end else begin
                    o_cmd.jac_step = 1'b1;
                end
            end
            prf_pkg::S_BASE_LD: begin
                o_cmd.base_ld = 1'b1;
                n_state = prf_pkg::S_BASE_JAC;
            end
            prf_pkg::S_BASE_JAC: begin
                if (i_stat.jac_done) begin
                    o_cmd.base_wr = 1'b1;
                    n_idx = '0;
                    n_state = (w_nfilt == '0) ? prf_pkg::S_DONE : prf_pkg::S_FILT_RD;
                end else begin
                    o_cmd.jac_step = 1'b1;
                end
            end
            prf_pkg::S_FILT_RD: n_state = prf_pkg::S_FILT_SYM;
            prf_pkg::S_FILT_SYM: begin
                o_cmd.filt_sym = 1'b1;
                n_state = prf_pkg::S_FILT_EVAL;
            end
            prf_pkg::S_FILT_EVAL: begin
                o_cmd.filt_eval = 1'b1;
                n_idx = w_idx_inc;
                n_state = (w_idx_inc == w_nfilt) ? prf_pkg::S_DONE : prf_pkg::S_FILT_RD;
            end
            prf_pkg::S_DONE: begin
                // hold the finished item until the output register frees up
                if (!r_valid || !i_stall) begin
                    o_cmd.publish = 1'b1;
                    n_valid = 1'b1;
                    n_state = prf_pkg::S_IDLE;
                end
            end
            default: n_state = prf_pkg::S_IDLE;
        endcase
    end

endmodule

### sv/prime_residue_filter.sv
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_operation i_slot i_core_value i_filter_kind
//         |         |         | i_k_slot i_c_slot i_prime
// output  | o_valid | i_stall | o_power_two_mask o_residue_pass_mask
//
// Loads leave the block idle; a test prime is taken only when idle.
// A test walks, per core, the states read, load and Jacobi steps; then the base load
// and its Jacobi steps; then read, symbol and evaluate per filter; then done. Jacobi
// steps (one halve, swap or subtract each) run on the shared Jacobi datapath.
// Synchronous active-low reset clears control; tables are undefined until loaded.
// A stalled result waits in the output register while loads and a new test proceed.
module prime_residue_filter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_operation,
    input  logic [prf_pkg::SLOT_W-1:0]    i_slot,
    input  logic [prf_pkg::DATA_W-1:0]    i_core_value,
    input  logic [prf_pkg::KIND_W-1:0]    i_filter_kind,
    input  logic [prf_pkg::SLOT_W-1:0]    i_k_slot,
    input  logic [prf_pkg::SLOT_W-1:0]    i_c_slot,
    input  logic [prf_pkg::DATA_W-1:0]    i_prime,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [prf_pkg::POW_W-1:0]     o_power_two_mask,
    output logic [prf_pkg::MASK_W-1:0]    o_residue_pass_mask,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prf_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [prf_pkg::BASE_W-1:0] r_base;
    logic [prf_pkg::CNT_W-1:0]  r_core_cnt;
    logic [prf_pkg::CNT_W-1:0]  r_filt_cnt;
    prf_pkg::t_cmd              w_cmd;
    prf_pkg::t_stat             w_stat;
    logic                       w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= prf_pkg::BASE_RESET;
            r_core_cnt <= '0;
            r_filt_cnt <= '0;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                prf_pkg::REG_BASE:     r_base     <= pwdata;
                prf_pkg::REG_CORE_CNT: r_core_cnt <= pwdata[prf_pkg::CNT_W-1:0];
                prf_pkg::REG_FILT_CNT: r_filt_cnt <= pwdata[prf_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            prf_pkg::REG_BASE:     prdata = r_base;
            prf_pkg::REG_CORE_CNT: prdata = 32'(r_core_cnt);
            prf_pkg::REG_FILT_CNT: prdata = 32'(r_filt_cnt);
            default:               prdata = '0;
        endcase
    end

    prf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_operation    (i_operation),
        .i_core_count   (r_core_cnt),
        .i_filter_count (r_filt_cnt),
        .i_stall        (i_stall),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .o_stall        (o_stall),
        .o_valid        (o_valid)
    );

    prf_dp u_dp (
        .i_clk               (i_clk),
        .i_cmd               (w_cmd),
        .i_slot              (i_slot),
        .i_core_value        (i_core_value),
        .i_filter_kind       (i_filter_kind),
        .i_k_slot            (i_k_slot),
        .i_c_slot            (i_c_slot),
        .i_prime             (i_prime),
        .i_base              (r_base),
        .o_stat              (w_stat),
        .o_power_two_mask    (o_power_two_mask),
        .o_residue_pass_mask (o_residue_pass_mask)
    );

endmodule

### sv/prf_checker.sv
module prf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [1:0]                    i_operation,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [prf_pkg::POW_W-1:0]     o_power_two_mask,
    input logic [prf_pkg::MASK_W-1:0]    o_residue_pass_mask
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_power_two_mask) && $stable(o_residue_pass_mask))
        else $error("stalled result changed");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_operation != prf_pkg::OP_TEST) |=> !o_stall)
        else $error("load item left the block busy");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_operation == prf_pkg::OP_TEST) |=> o_stall)
        else $error("test item did not start work");

    a_rise_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !o_stall)
        else $error("result shown while still busy");

endmodule

bind prime_residue_filter prf_checker u_prf_checker (.*);
